// ----- rtl/lkxc_pkg.sv -----
// Package: shared types, register codes and keystream constants of the XOR cipher.
`timescale 1ns / 1ps
package lkxc_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [31:0] LCG_MUL      = 32'd214013;
  localparam logic [31:0] LCG_ADD      = 32'd2531011;
  localparam int unsigned TEMPER_SHIFT = 15;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_HALF   = 2'd1,
    MODE_WORD   = 2'd2,
    MODE_STREAM = 2'd3
  } mode_t;

  // Register select is address bit 2 (registers at byte addresses 0 and 4).
  typedef enum logic {
    REG_MODE = 1'b0,
    REG_KEY  = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       last_out;
  } res_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] key;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] lane;
    logic       start;
  } cmd_t;

endpackage

// ----- rtl/lkxc_regs.sv -----
// Configuration registers: mode and key, behind an APB-style port.
`timescale 1ns / 1ps
module lkxc_regs import lkxc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_sel_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_BYTE;
      cfg.key  <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_MODE: cfg.mode <= mode_t'(pwdata[1:0]);
        REG_KEY:  cfg.key  <= pwdata;
        default:  cfg.key  <= cfg.key;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_MODE: prdata = {{(DATA_W-2){1'b0}}, cfg.mode};
      REG_KEY:  prdata = cfg.key;
      default:  prdata = '0;
    endcase
  end

endmodule

// ----- rtl/lkxc_front.sv -----
// Front end: accepts message bytes and tags each with its lane and message start.
`timescale 1ns / 1ps
module lkxc_front import lkxc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  msg_t message,
  output logic full,
  input  logic q_full,
  output logic q_push,
  output cmd_t cmd
);

  logic       message_open;
  logic [1:0] lane;
  logic [1:0] lane_now;

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign lane_now = message_open ? lane : 2'd0;

  always_comb begin
    cmd.data_byte = message.data_byte;
    cmd.last      = message.end_of_message;
    cmd.lane      = lane_now;
    cmd.start     = !message_open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_open <= 1'b0;
      lane         <= 2'd0;
    end else if (q_push) begin
      // close the message and rewind the lane on its last byte
      message_open <= !message.end_of_message;
      lane         <= message.end_of_message ? 2'd0 : lane_now + 2'd1;
    end
  end

endmodule

// ----- rtl/lkxc_cmd_queue.sv -----
// Two-entry queue of tagged bytes between front end and back end.
`timescale 1ns / 1ps
module lkxc_cmd_queue import lkxc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output cmd_t cmd_out,
  output logic empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/lkxc_back.sv -----
// Back end: keystream generator, key byte select, XOR and result queue.
`timescale 1ns / 1ps
module lkxc_back import lkxc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic pop,
  output logic empty,
  output res_t result
);

  logic [31:0] seed;
  logic [31:0] ks_word;
  logic [31:0] seed_base;
  logic [31:0] seed_adv;
  logic [31:0] word_adv;
  logic [31:0] word_now;
  logic [7:0]  key_byte;
  res_t        res_new;

  res_t        out_mem [2];
  logic        out_wr;
  logic        out_rd;
  logic [1:0]  out_cnt;
  logic        out_full;
  logic        out_pop;

  assign out_full = (out_cnt == 2'd2);
  assign empty    = (out_cnt == 2'd0);
  assign out_pop  = pop && !empty;
  assign cmd_pop  = !cmd_empty && !out_full;
  assign result   = out_mem[out_rd];

  // reload the seed at message start, advance it at every lane 0
  always_comb begin
    seed_base = cmd.start ? cfg.key : seed;
    seed_adv  = seed_base * LCG_MUL + LCG_ADD;
    word_adv  = seed_adv ^ (seed_adv >> TEMPER_SHIFT);
    word_now  = (cmd.lane == 2'd0) ? word_adv : ks_word;
  end

  always_comb begin
    case (cfg.mode)
      MODE_BYTE:   key_byte = cfg.key[7:0];
      MODE_HALF:   key_byte = cmd.lane[0] ? cfg.key[15:8] : cfg.key[7:0];
      MODE_WORD:   key_byte = cfg.key[{cmd.lane, 3'b000} +: 8];
      MODE_STREAM: key_byte = word_now[{cmd.lane, 3'b000} +: 8];
      default:     key_byte = cfg.key[7:0];
    endcase
    res_new.coded_byte = cmd.data_byte ^ key_byte;
    res_new.last_out   = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.lane == 2'd0)) begin
      seed    <= seed_adv;
      ks_word <= word_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_mem[out_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr  <= 1'b0;
      out_rd  <= 1'b0;
      out_cnt <= 2'd0;
    end else begin
      if (cmd_pop) out_wr <= !out_wr;
      if (out_pop) out_rd <= !out_rd;
      case ({cmd_pop, out_pop})
        2'b10:   out_cnt <= out_cnt + 2'd1;
        2'b01:   out_cnt <= out_cnt - 2'd1;
        default: out_cnt <= out_cnt;
      endcase
    end
  end

endmodule

// ----- rtl/lcg_keystream_xor_cipher.sv -----
// Top level: XOR byte cipher with fixed keys or an LCG keystream.
//
//   channel   handshake          payload
//   input     push / full        message (data_byte, end_of_message)
//   result    pop / empty        result  (coded_byte, last_out)
//   config    psel/penable/...   pwdata: mode at 0x0, key at 0x4
//
// One byte per cycle sustained while results are popped; the one multiply-add of
// the generator sits in the back end and sets the cycle. Each byte passes the
// command queue, then the result queue. Reset (rst, synchronous) empties both
// queues, closes any open message and sets mode and key to zero. Two-entry queues
// on each side let input keep flowing while a finished result waits for pop.
`timescale 1ns / 1ps
module lcg_keystream_xor_cipher import lkxc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              push,
  input  msg_t              message,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output res_t              result
);

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic q_full;
  logic q_push;
  logic q_empty;
  logic q_pop;

  lkxc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lkxc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .message (message),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .cmd     (cmd_in)
  );

  lkxc_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (cmd_out),
    .empty   (q_empty)
  );

  lkxc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_out),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

// ----- rtl/lkxc_checker.sv -----
// Checker: port-level assertions on the cipher, bound to the top level.
`timescale 1ns / 1ps
module lkxc_checker import lkxc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic pop,
  input logic empty,
  input res_t result
);

  logic [2:0] outstanding;

  // track transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 3'd0;
    end else begin
      case ({push && !full, pop && !empty})
        2'b10:   outstanding <= outstanding + 3'd1;
        2'b01:   outstanding <= outstanding - 3'd1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (outstanding == 3'd0) |-> empty)
    else $error("result shown with no transaction outstanding");

  a_full_backed: assert property (@(posedge clk) disable iff (rst)
    full |-> (outstanding >= 3'd2))
    else $error("full raised with queue not filled");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or dropped");

endmodule

bind lcg_keystream_xor_cipher lkxc_checker u_lkxc_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);

// ----- tb/tb_lcg_keystream_xor_cipher.sv -----
// Testbench: self-checking stimulus and prediction for the LCG keystream XOR cipher.
`timescale 1ns / 1ps
module tb_lcg_keystream_xor_cipher;
  import lkxc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned LONG_HOLD    = 300;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_HALF,
    POP_ONE_IN_FOUR,
    POP_RARE
  } pop_style_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push    = 1'b0;
  msg_t              message = '0;
  logic              full;
  logic              pop     = 1'b0;
  logic              empty;
  res_t              result;

  // Bytes waiting to be offered, and coded bytes the block still owes.
  msg_t plain_q[$];
  res_t coded_q[$];

  // Predictor copy of the configuration and the cipher state.
  mode_t       cfg_mode = MODE_BYTE;
  logic [31:0] cfg_key  = '0;
  logic [1:0]  lane     = '0;
  logic [31:0] seed     = '0;
  logic [31:0] ks_word  = '0;
  bit          msg_open = 1'b0;

  int unsigned cycle_count   = 0;
  int unsigned err_count     = 0;
  int unsigned burst_left    = 1;
  int unsigned gap_left      = 0;
  bit          sender_hold   = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned style_left    = 0;
  pop_style_t  pop_style     = POP_ALWAYS;

  lcg_keystream_xor_cipher u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .message (message),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cipher_predict(msg_t m);
    logic [7:0] key_byte;
    res_t       r;
    if (!msg_open) begin
      seed     = cfg_key;
      lane     = '0;
      msg_open = 1'b1;
    end
    // The generator steps at every word start, whatever the mode.
    if (lane == 2'd0) begin
      seed    = seed * LCG_MUL + LCG_ADD;
      ks_word = seed ^ (seed >> TEMPER_SHIFT);
    end
    case (cfg_mode)
      MODE_BYTE: key_byte = cfg_key[7:0];
      MODE_HALF: key_byte = lane[0] ? cfg_key[15:8] : cfg_key[7:0];
      MODE_WORD: key_byte = cfg_key[8*lane +: 8];
      default:   key_byte = ks_word[8*lane +: 8];
    endcase
    r.coded_byte = m.data_byte ^ key_byte;
    r.last_out   = m.end_of_message;
    coded_q.push_back(r);
    lane = lane + 2'd1;
    if (m.end_of_message) begin
      msg_open = 1'b0;
      lane     = '0;
    end
  endtask

  always @(posedge clk) begin : drive_input
    bit   offer;
    msg_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      offer = push;
      nxt   = message;
      if (push && !full) begin
        cipher_predict(message);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!sender_hold && plain_q.size() > 0) begin
          nxt   = plain_q.pop_front();
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7:       gap_left = $urandom_range(15, 30);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end
      end
      push    <= offer;
      message <= nxt;
    end
  end

  always @(posedge clk) begin : check_result
    res_t want;
    bit   nxt_pop;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (coded_q.size() == 0) begin
          $error("unexpected transaction: coded_byte %02h last_out %b",
                 result.coded_byte, result.last_out);
          err_count++;
        end else begin
          want = coded_q.pop_front();
          if (result.coded_byte !== want.coded_byte) begin
            $error("coded_byte: expected %02h, got %02h", want.coded_byte, result.coded_byte);
            err_count++;
          end
          if (result.last_out !== want.last_out) begin
            $error("last_out: expected %b, got %b", want.last_out, result.last_out);
            err_count++;
          end
        end
      end
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        pop_style  = pop_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 80);
      end else begin
        style_left--;
      end
      case (pop_style)
        POP_ALWAYS:      nxt_pop = 1'b1;
        POP_HALF:        nxt_pop = 1'($urandom_range(0, 1));
        POP_ONE_IN_FOUR: nxt_pop = (cycle_count[1:0] == 2'd0);
        default:         nxt_pop = ($urandom_range(0, 7) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        nxt_pop = 1'b0;
      end
      pop <= nxt_pop;
    end
  end

  task automatic add_byte(logic [7:0] d, logic l);
    msg_t m;
    m.data_byte      = d;
    m.end_of_message = l;
    plain_q.push_back(m);
  endtask

  // Hold until every byte is sent and every coded byte has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (plain_q.size() != 0 || push || coded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write a register, then read it back.
  task automatic set_reg(reg_sel_t sel, logic [31:0] val);
    logic [31:0] want;
    logic [31:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (sel == REG_MODE) cfg_mode = mode_t'(val[1:0]);
    else cfg_key = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got  = prdata;
    want = (sel == REG_MODE) ? {30'd0, cfg_mode} : cfg_key;
    if (sel == REG_MODE) begin
      got  = {30'd0, got[1:0]};
    end
    if (got !== want) begin
      $error("prdata: expected %08h, got %08h", want, got);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned n_items;
    int unsigned len;
    int unsigned k;
    int unsigned half;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of reset: byte mode with a zero key.
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    wait_drained();

    // Upper bits of the mode write must be dropped.
    set_reg(REG_KEY, 32'hA5C3_3C5A);
    set_reg(REG_MODE, 32'hFFFF_FFFC);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h5A, 1'b1);
    wait_drained();

    set_reg(REG_MODE, {30'd0, MODE_HALF});
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    wait_drained();

    // Word key across a word boundary.
    set_reg(REG_MODE, {30'd0, MODE_WORD});
    set_reg(REG_KEY, 32'h8142_7EBD);
    for (k = 0; k < 5; k++) add_byte(8'h00, k == 4);
    wait_drained();

    // Keystream from a zero seed, with a trailing partial word, then a one-byte message.
    set_reg(REG_MODE, {30'd0, MODE_STREAM});
    set_reg(REG_KEY, 32'h0000_0000);
    for (k = 0; k < 6; k++) add_byte(8'h00, k == 5);
    add_byte(8'hFF, 1'b1);
    wait_drained();

    // New seed mid-message applies only from the next message start.
    set_reg(REG_KEY, 32'hFFFF_FFFF);
    for (k = 0; k < 3; k++) add_byte(8'h3C, 1'b0);
    wait_drained();
    set_reg(REG_KEY, 32'h1357_9BDF);
    add_byte(8'hC3, 1'b0);
    add_byte(8'h81, 1'b1);
    for (k = 0; k < 2; k++) add_byte(8'h00, k == 1);
    // Mode change mid-message applies on the next byte.
    add_byte(8'h7E, 1'b0);
    wait_drained();
    set_reg(REG_MODE, {30'd0, MODE_WORD});
    add_byte(8'h7E, 1'b1);
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: set_reg(REG_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)),
                              2'($urandom_range(0, 3))});
        1: set_reg(REG_KEY, ($urandom_range(0, 3) == 0) ? {32{$urandom_range(0, 1) == 1}}
                                                        : $urandom);
        default: begin
          set_reg(REG_MODE, $urandom_range(0, 3));
          set_reg(REG_KEY, ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom);
        end
      endcase

      n_items = $urandom_range(40, 110);
      k = 0;
      while (k < n_items) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
        // The final message may run past the phase and stay open.
        for (int unsigned b = 0; b < len && k < n_items; b++) begin
          add_byte(8'($urandom_range(0, 255)), b == len - 1);
          k++;
        end
      end
      sent += n_items;

      if (phase == 1 || phase == 6) begin
        hold_requests++;
      end else if (phase == 3) begin
        half = n_items / 2;
        while (plain_q.size() > half) @(negedge clk);
        sender_hold = 1'b1;
        while (push || coded_q.size() != 0) @(negedge clk);
        repeat (5) @(negedge clk);
        sender_hold = 1'b0;
      end
      phase++;
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (err_count == 0 && coded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
